### rtl/core/fixed_width_string_sorter_unit_assert.svh
// assertion macros for the sorter rtl
`ifndef FIXED_WIDTH_STRING_SORTER_UNIT_ASSERT_SVH
`define FIXED_WIDTH_STRING_SORTER_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define FWSS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FWSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/fwss_pkg.sv
package fwss_pkg;

  localparam int MAX_KEYS    = 16;
  localparam int KEY_BYTES   = 30;
  localparam int FIELD_BYTES = 30;
  localparam int KEY_W       = 8 * FIELD_BYTES;
  localparam int IDX_W       = $clog2(MAX_KEYS);
  localparam int CNT_W       = $clog2(MAX_KEYS + 1);
  localparam int S_DATA_W    = KEY_W;
  localparam int M_DATA_W    = ((KEY_W + CNT_W + 7) / 8) * 8;

  // byte 0 of the string sits in the top bits, so an unsigned compare is lexicographic
  typedef logic [KEY_W-1:0] key_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_RD_I,
    ST_CUR,
    ST_CMP,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    RD_I,
    RD_J,
    RD_J_NEXT
  } rd_sel_e;

  typedef struct packed {
    logic    load_we;
    logic    drop_set;
    logic    run_clr;
    logic    i_clr;
    logic    i_inc;
    logic    j_set;
    logic    j_inc;
    rd_sel_e rd_sel;
    logic    cur_load;
    logic    cmp_step;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic j_ok;
    logic j_next_ok;
    logic i_last;
  } dp_stat_t;

  // truncate to KEY_BYTES-1 characters and clear everything after the terminator
  function automatic key_t clean_key(key_t raw);
    logic ended;
    key_t k;
    ended = 1'b0;
    k     = raw;
    for (int b = 0; b < FIELD_BYTES; b++) begin
      if (b >= KEY_BYTES - 1 || k[KEY_W-1-8*b -: 8] == 8'h00) begin
        ended = 1'b1;
      end
      if (ended) begin
        k[KEY_W-1-8*b -: 8] = 8'h00;
      end
    end
    return k;
  endfunction

endpackage

### rtl/core/fwss_dp.sv
module fwss_dp import fwss_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dp_cmd_t          cmd_i,
  input  key_t             in_key_i,
  output dp_stat_t         stat_o,
  output key_t             cur_key_o,
  output logic [CNT_W-1:0] count_o,
  output logic             drop_o
);

  key_t             mem_q [MAX_KEYS];
  key_t             rd_q;
  key_t             cur_q;
  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] i_q;
  logic [CNT_W-1:0] j_q;
  logic             drop_q;
  logic [CNT_W:0]   j_next;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  logic             wr_en;
  key_t             wr_data;
  logic             swap;

  assign j_next = {1'b0, j_q} + (CNT_W+1)'(1);

  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_I:      rd_addr = i_q[IDX_W-1:0];
      RD_J:      rd_addr = j_q[IDX_W-1:0];
      RD_J_NEXT: rd_addr = j_next[IDX_W-1:0];
      default:   rd_addr = j_q[IDX_W-1:0];
    endcase
  end

  // running minimum moves down, the larger key goes back into slot j
  assign swap    = cmd_i.cmp_step && (cur_q > rd_q);
  assign wr_en   = cmd_i.load_we || swap;
  assign wr_addr = cmd_i.load_we ? count_q[IDX_W-1:0] : j_q[IDX_W-1:0];
  assign wr_data = cmd_i.load_we ? clean_key(in_key_i) : cur_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cur_load || swap) begin
      cur_q <= rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      drop_q  <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
    end else begin
      if (cmd_i.run_clr) begin
        count_q <= '0;
        drop_q  <= 1'b0;
      end else begin
        if (cmd_i.load_we) begin
          count_q <= count_q + CNT_W'(1);
        end
        if (cmd_i.drop_set) begin
          drop_q <= 1'b1;
        end
      end
      if (cmd_i.i_clr) begin
        i_q <= '0;
      end else if (cmd_i.i_inc) begin
        i_q <= i_q + CNT_W'(1);
      end
      if (cmd_i.j_set) begin
        j_q <= i_q + CNT_W'(1);
      end else if (cmd_i.j_inc) begin
        j_q <= j_q + CNT_W'(1);
      end
    end
  end

  assign stat_o.full      = (count_q == CNT_W'(MAX_KEYS));
  assign stat_o.j_ok      = (j_q < count_q);
  assign stat_o.j_next_ok = (j_next < {1'b0, count_q});
  assign stat_o.i_last    = (({1'b0, i_q} + (CNT_W+1)'(1)) == {1'b0, count_q});

  assign cur_key_o = cur_q;
  assign count_o   = count_q;
  assign drop_o    = drop_q;

endmodule

### rtl/core/fwss_ctrl.sv
module fwss_ctrl import fwss_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_last_i,
  input  logic     out_ready_i,
  input  dp_stat_t stat_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  output dp_cmd_t  cmd_o
);

  state_e state_q;
  state_e state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_valid_i && in_last_i) begin
          state_d = ST_RD_I;
        end
      end
      ST_RD_I: state_d = ST_CUR;
      ST_CUR:  state_d = stat_i.j_ok ? ST_CMP : ST_EMIT;
      ST_CMP:  state_d = stat_i.j_next_ok ? ST_CMP : ST_EMIT;
      ST_EMIT: begin
        if (out_ready_i) begin
          state_d = stat_i.i_last ? ST_LOAD : ST_RD_I;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.rd_sel = RD_J;
    in_ready_o   = 1'b0;
    out_valid_o  = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_we  = !stat_i.full;
          cmd_o.drop_set = stat_i.full;
          cmd_o.i_clr    = in_last_i;
        end
      end
      ST_RD_I: begin
        cmd_o.rd_sel = RD_I;
        cmd_o.j_set  = 1'b1;
      end
      ST_CUR: begin
        cmd_o.cur_load = 1'b1;
        cmd_o.rd_sel   = RD_J;
      end
      ST_CMP: begin
        cmd_o.cmp_step = 1'b1;
        cmd_o.j_inc    = 1'b1;
        cmd_o.rd_sel   = RD_J_NEXT;
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.i_inc   = 1'b1;
          cmd_o.run_clr = stat_i.i_last;
        end
      end
      default: begin
        cmd_o.rd_sel = RD_J;
      end
    endcase
  end

endmodule

### rtl/core/fixed_width_string_sorter_unit.sv
// sorts a run of up to MAX_KEYS zero-padded string keys into ascending byte order
// input stream: one key per word, tlast marks the final key of a run; keys beyond
// the store size are dropped and flagged. words are accepted one per cycle, only while loading.
// on the tlast word the sort starts: pass i holds the running minimum of slots
// i..n-1 in a register and compares it against one slot per cycle through the
// single read port of the key store, writing the larger key back
// each pass reads slot i, loads it as the running minimum, compares it with the
// later slots and then hands its minimum out as one output word
// output stream: one word per stored key, tlast on the final one, the run's key
// count in tdata and the overflow flag in tuser on every word
// when the receiver stalls, the sort waits with the word held on the port
// after the last output word the block takes the next run
// reset empties the run (count and overflow cleared), store contents are not cleared
`include "fixed_width_string_sorter_unit_assert.svh"

module fixed_width_string_sorter_unit import fwss_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // key_bytes_0_7, key_bytes_8_15, key_bytes_16_23, key_bytes_24_29
  input  logic [S_DATA_W-1:0] s_axis_tdata_i,
  input  logic                s_axis_tlast_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // sorted_bytes_0_7, sorted_bytes_8_15, sorted_bytes_16_23, sorted_bytes_24_29,
  // total_count, zero fill
  output logic [M_DATA_W-1:0] m_axis_tdata_o,
  // overflow
  output logic                m_axis_tuser_o,
  output logic                m_axis_tlast_o
);

  dp_cmd_t          cmd;
  dp_stat_t         stat;
  key_t             in_key;
  key_t             cur_key;
  logic [CNT_W-1:0] count;
  logic             drop;

  // byte 0 goes to the top of the compare word
  assign in_key = {s_axis_tdata_i[63:0], s_axis_tdata_i[127:64],
                   s_axis_tdata_i[191:128], s_axis_tdata_i[239:192]};

  fwss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_last_i   (s_axis_tlast_i),
    .out_ready_i (m_axis_tready_i),
    .stat_i      (stat),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .cmd_o       (cmd)
  );

  fwss_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .in_key_i  (in_key),
    .stat_o    (stat),
    .cur_key_o (cur_key),
    .count_o   (count),
    .drop_o    (drop)
  );

  assign m_axis_tdata_o = {(M_DATA_W-KEY_W-CNT_W)'(0), count,
                           cur_key[47:0], cur_key[111:48],
                           cur_key[175:112], cur_key[239:176]};
  assign m_axis_tuser_o = drop;
  assign m_axis_tlast_o = stat.i_last;

  `FWSS_ASSERT_IMPL(a_one_side, 1'b1, !(s_axis_tready_o && m_axis_tvalid_o), "load and emit overlap")
  `FWSS_ASSERT_IMPL(a_count_range, m_axis_tvalid_o, (count != '0) && (count <= CNT_W'(MAX_KEYS)), "bad key count on output")
  `FWSS_ASSERT_IMPL(a_ovf_full, m_axis_tvalid_o && drop, count == CNT_W'(MAX_KEYS), "overflow without full store")
  `FWSS_ASSERT_NEXT(a_run_done, m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o, s_axis_tready_o && (count == '0) && !drop, "run not cleared after last word")

endmodule

### dv/fixed_width_string_sorter_unit_tb.sv
`timescale 1ns / 100ps

module fixed_width_string_sorter_unit_tb;
  import fwss_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int TAIL_CYCLES = 40;
  localparam int RANDOM_WORDS = 500;

  typedef logic [S_DATA_W-1:0] key_word_t;
  typedef logic [KEY_W-1:0] lex_key_t;

  typedef struct {
    key_word_t        key;
    logic             last;
    logic [CNT_W-1:0] count;
    logic             ovf;
  } sorted_word_t;

  class sorted_key_board;
    lex_key_t     run_keys[$];
    bit           run_dropped;
    sorted_word_t sorted_pending[$];
    int           errors;

    // bit offset of string byte b inside a packed word
    static function int byte_pos(int b);
      return (b < 24) ? 64 * (b / 8) + 56 - 8 * (b % 8) : 192 + 40 - 8 * (b - 24);
    endfunction

    static function lex_key_t to_lex(key_word_t d);
      lex_key_t k;
      for (int b = 0; b < FIELD_BYTES; b++) begin
        k[KEY_W-1-8*b -: 8] = d[byte_pos(b) +: 8];
      end
      return k;
    endfunction

    static function key_word_t from_lex(lex_key_t k);
      key_word_t d;
      d = '0;
      for (int b = 0; b < FIELD_BYTES; b++) begin
        d[byte_pos(b) +: 8] = k[KEY_W-1-8*b -: 8];
      end
      return d;
    endfunction

    function void note_key(key_word_t data, bit last);
      lex_key_t     k;
      lex_key_t     tmp;
      bit           ended;
      int           n;
      sorted_word_t w;
      k = to_lex(data);
      ended = 1'b0;
      // truncate and wipe everything after the terminator
      for (int b = 0; b < FIELD_BYTES; b++) begin
        if (b >= KEY_BYTES - 1 || k[KEY_W-1-8*b -: 8] == 8'h00) ended = 1'b1;
        if (ended) k[KEY_W-1-8*b -: 8] = 8'h00;
      end
      if (run_keys.size() < MAX_KEYS) run_keys.push_back(k);
      else run_dropped = 1'b1;
      if (!last) return;
      n = run_keys.size();
      for (int i = 0; i < n; i++) begin
        for (int j = i + 1; j < n; j++) begin
          if (run_keys[i] > run_keys[j]) begin
            tmp = run_keys[i];
            run_keys[i] = run_keys[j];
            run_keys[j] = tmp;
          end
        end
      end
      for (int i = 0; i < n; i++) begin
        w.key   = from_lex(run_keys[i]);
        w.last  = (i == n - 1);
        w.count = n[CNT_W-1:0];
        w.ovf   = run_dropped;
        sorted_pending.push_back(w);
      end
      run_keys.delete();
      run_dropped = 1'b0;
    endfunction

    function void cmp_field(string name, logic [63:0] e, logic [63:0] a);
      if (e !== a) begin
        errors++;
        $display("%0t: %s mismatch, expected %h actual %h", $time, name, e, a);
      end
    endfunction

    function void check_word(logic [M_DATA_W-1:0] data, logic ovf, logic last);
      sorted_word_t w;
      if (sorted_pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected output word, expected none actual %h", $time, data);
        return;
      end
      w = sorted_pending.pop_front();
      for (int f = 0; f < 3; f++) begin
        cmp_field($sformatf("sorted bytes %0d..%0d", 8 * f, 8 * f + 7),
                  w.key[64*f +: 64], data[64*f +: 64]);
      end
      cmp_field("sorted bytes 24..29", 64'(w.key[192 +: 48]), 64'(data[192 +: 48]));
      cmp_field("total count", 64'(w.count), 64'(data[KEY_W +: CNT_W]));
      cmp_field("overflow", 64'(w.ovf), 64'(ovf));
      cmp_field("last", 64'(w.last), 64'(last));
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  logic [S_DATA_W-1:0] s_axis_tdata_i;
  logic                s_axis_tlast_i;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i;
  logic [M_DATA_W-1:0] m_axis_tdata_o;
  logic                m_axis_tuser_o;
  logic                m_axis_tlast_o;

  sorted_key_board sorted_board;
  bit              tx_steady;
  bit              rx_steady;
  int              idle_cycles;
  int              words_sent;

  fixed_width_string_sorter_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic int pick_gap(bit steady);
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // style 0: any nonzero byte, 1: tiny alphabet for shared prefixes, 2: extreme bytes,
  // 3: raw noise
  function automatic key_word_t make_key(int style);
    lex_key_t k;
    int       len;
    bit       junk_tail;
    logic [7:0] c;
    k = '0;
    if (style == 3) begin
      for (int i = 0; i < 8; i++) k = (k << 32) | lex_key_t'($urandom);
      return sorted_key_board::from_lex(k);
    end
    len = (style == 1) ? $urandom_range(0, 5) : $urandom_range(0, 32);
    junk_tail = 1'($urandom_range(0, 1));
    for (int b = 0; b < FIELD_BYTES; b++) begin
      if (b < len) begin
        case (style)
          0: c = 8'($urandom_range(1, 255));
          1: c = 8'h61 + 8'($urandom_range(0, 2));
          default: c = ($urandom_range(0, 1) != 0) ? 8'h01 : 8'hff;
        endcase
      end else if (b > len && junk_tail) begin
        c = 8'($urandom_range(0, 255));
      end else begin
        c = 8'h00;
      end
      k[KEY_W-1-8*b -: 8] = c;
    end
    return sorted_key_board::from_lex(k);
  endfunction

  task automatic send_key(input key_word_t data, input bit last);
    int gap;
    gap = pick_gap(tx_steady);
    if (gap > 0) begin
      s_axis_tvalid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = data;
    s_axis_tlast_i  = last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sorted_board.note_key(data, last);
    words_sent++;
    @(negedge clk_i);
  endtask

  // output side: accept and check at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      sorted_board.check_word(m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((s_axis_tvalid_i && s_axis_tready_o) ||
                 (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
      $display("fixed_width_string_sorter_unit_tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int gap;
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      gap = pick_gap(rx_steady);
      if (gap > 0) begin
        m_axis_tready_i = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end else begin
        m_axis_tready_i = 1'b1;
        repeat ($urandom_range(0, 7)) @(negedge clk_i);
      end
    end
  end

  initial begin
    int r;
    int n;
    int style;
    sorted_board    = new();
    tx_steady       = 1'b0;
    rx_steady       = 1'b0;
    words_sent      = 0;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tlast_i  = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // all ones gets truncated, all zeros is the empty string, junk after a terminator
    send_key('1, 1'b0);
    send_key('0, 1'b0);
    send_key(sorted_key_board::from_lex({8'h62, 8'h00, {28{8'ha5}}}), 1'b0);
    send_key(sorted_key_board::from_lex({8'h61, {29{8'h00}}}), 1'b1);
    // single-key run
    send_key(make_key(0), 1'b1);
    // full store plus one dropped final key, duplicates likely
    for (int i = 0; i <= MAX_KEYS; i++) send_key(make_key(1), i == MAX_KEYS);

    while (words_sent < RANDOM_WORDS + 22) begin
      r = $urandom_range(0, 99);
      if (r < 10) n = $urandom_range(MAX_KEYS + 1, MAX_KEYS + 4);
      else if (r < 22) n = MAX_KEYS;
      else n = $urandom_range(1, 12);
      style = $urandom_range(0, 3);
      tx_steady = ($urandom_range(0, 4) == 0);
      rx_steady = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < n; i++) send_key(make_key(style), i == n - 1);
    end
    s_axis_tvalid_i = 1'b0;
    rx_steady = 1'b0;

    while (sorted_board.sorted_pending.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sorted_board.errors == 0) begin
      $display("fixed_width_string_sorter_unit_tb: PASS");
    end else begin
      $display("fixed_width_string_sorter_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
